// ===== rtl/core/bba_pkg.sv =====
// Package: shared constants and result codes of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

  // Field widths of the request and response transfers.
  localparam int unsigned ModeW   = 1;
  localparam int unsigned LevelW  = 4;
  localparam int unsigned AddrW   = 12;
  localparam int unsigned StatusW = 2;

  // Default geometry.
  localparam int unsigned LevelsDef   = 12;
  localparam int unsigned AddrBitsDef = 12;

  // Request modes.
  localparam logic [ModeW-1:0] MODE_ALLOC = 1'b0;
  localparam logic [ModeW-1:0] MODE_FREE  = 1'b1;

  // Response status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_RANGE  = 2'd2
  } status_e;

endpackage

// ===== rtl/core/bba_req_if.sv =====
// Interface: request channel (mode, level, block address) with valid/ready.
`timescale 1ns / 1ps

interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [LevelW-1:0] level;
  logic [AddrW-1:0]  block_address;

  modport source (output valid, mode, level, block_address, input ready);
  modport sink   (input valid, mode, level, block_address, output ready);
endinterface

// ===== rtl/core/bba_rsp_if.sv =====
// Interface: response channel (status, granted address, final level) with valid/ready.
`timescale 1ns / 1ps

interface bba_rsp_if import bba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   granted_address;
  logic [LevelW-1:0]  final_level;

  modport source (output valid, status, granted_address, final_level, input ready);
  modport sink   (input valid, status, granted_address, final_level, output ready);
endinterface

// ===== rtl/core/buddy_block_allocator_top.sv =====
// Top level: binary buddy block allocator with request sequencer and response register.
//
// Usage:
//   req_i carries one command per transfer: mode (0 allocate, 1 free), level
//   (block size as a power of two of minimum blocks) and block_address (used
//   on free only). rsp_o returns exactly one transfer per command: status,
//   granted_address and final_level, in command order.
//   Commands are handled one at a time by a sequencer around one shared
//   buddy unit, the per-level head registers and the next-link memory
//   (one write and one registered read per cycle).
// Sequence per command (response side free):
//   range error: answered from the accept without touching the lists.
//   allocate: scan upward to j, the first non-empty level at or above L, pop
//     its head, then split down to L; no free block: scan up to the top level.
//   free: at each level visited, walk the list for the buddy; on a match unlink
//     it and merge one level up, else append the block at the tail.
//   The free-list walk through the link memory read port sets the rate.
// Reset: all free lists empty; the link memory is not cleared and needs no
//   clearing pass, since only listed blocks are ever read.
// Stall: a finished response waits in the output register; the next command
//   is accepted meanwhile and processed, then held until the register drains.
`timescale 1ns / 1ps

module buddy_block_allocator_top import bba_pkg::*; #(
  parameter int unsigned LEVELS    = LevelsDef,
  parameter int unsigned ADDR_BITS = AddrBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bba_req_if.sink   req_i,
  bba_rsp_if.source rsp_o
);

  localparam int unsigned LvlW = $clog2(LEVELS);
  localparam logic [LvlW-1:0] TopLvl = LvlW'(LEVELS - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_A_SCAN   = 4'd1;
  localparam logic [3:0] S_A_POP    = 4'd2;
  localparam logic [3:0] S_A_SPLIT  = 4'd3;
  localparam logic [3:0] S_F_LOAD   = 4'd4;
  localparam logic [3:0] S_F_WALK   = 4'd5;
  localparam logic [3:0] S_F_NEXT   = 4'd6;
  localparam logic [3:0] S_F_UNLINK = 4'd7;
  localparam logic [3:0] S_F_APPEND = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state_q, state_d;

  // Working registers of the command in flight.
  logic [LvlW-1:0]      lvl_q, lvl_d;
  logic [LvlW-1:0]      orig_q, orig_d;
  logic [ADDR_BITS-1:0] p_q, p_d;
  logic [ADDR_BITS:0]   cur_q, cur_d;
  logic [ADDR_BITS-1:0] prev_q, prev_d;
  logic                 has_prev_q, has_prev_d;
  logic [ADDR_BITS:0]   steps_q, steps_d;

  // Finished result waiting for the output register.
  status_e              res_status_q, res_status_d;
  logic [AddrW-1:0]     res_addr_q, res_addr_d;
  logic [LevelW-1:0]    res_lvl_q, res_lvl_d;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [AddrW-1:0]     out_addr_q, out_addr_d;
  logic [LevelW-1:0]    out_lvl_q, out_lvl_d;

  // Head registers.
  logic [ADDR_BITS:0]   head_rd;
  logic                 head_we;
  logic [LvlW-1:0]      head_wr_lvl;
  logic [ADDR_BITS:0]   head_wr_entry;

  // Link memory.
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [ADDR_BITS:0]   mem_wdata;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_raddr;
  logic [ADDR_BITS:0]   mem_rdata;

  // Shared buddy unit.
  logic [ADDR_BITS-1:0] bu_blk;
  logic [LvlW-1:0]      bu_lvl;
  logic [ADDR_BITS-1:0] bu_buddy;
  logic                 bu_match;
  logic [ADDR_BITS-1:0] bu_merged;

  logic [ADDR_BITS-1:0] cur_addr;
  logic                 req_oob;

  assign cur_addr = cur_q[ADDR_BITS-1:0];
  assign req_oob  = (32'(req_i.level) >= 32'(LEVELS));

  bba_heads #(
    .LEVELS    (LEVELS),
    .ADDR_BITS (ADDR_BITS)
  ) u_heads (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_lvl_i   (lvl_q),
    .rd_entry_o (head_rd),
    .we_i       (head_we),
    .wr_lvl_i   (head_wr_lvl),
    .wr_entry_i (head_wr_entry)
  );

  bba_link_mem #(
    .ADDR_BITS (ADDR_BITS)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Splitting uses the buddy of the popped block one level down; the walk
  // uses the buddy of the current list entry at the working level.
  always_comb begin
    if (state_q == S_A_SPLIT) begin
      bu_blk = p_q;
      bu_lvl = lvl_q - LvlW'(1);
    end else begin
      bu_blk = cur_addr;
      bu_lvl = lvl_q;
    end
  end

  bba_buddy_unit #(
    .LEVELS    (LEVELS),
    .ADDR_BITS (ADDR_BITS)
  ) u_buddy (
    .blk_i    (bu_blk),
    .lvl_i    (bu_lvl),
    .cmp_i    (p_q),
    .buddy_o  (bu_buddy),
    .match_o  (bu_match),
    .merged_o (bu_merged)
  );

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    lvl_d         = lvl_q;
    orig_d        = orig_q;
    p_d           = p_q;
    cur_d         = cur_q;
    prev_d        = prev_q;
    has_prev_d    = has_prev_q;
    steps_d       = steps_q;
    res_status_d  = res_status_q;
    res_addr_d    = res_addr_q;
    res_lvl_d     = res_lvl_q;
    out_valid_d   = out_valid_q & ~rsp_o.ready;
    out_status_d  = out_status_q;
    out_addr_d    = out_addr_q;
    out_lvl_d     = out_lvl_q;
    head_we       = 1'b0;
    head_wr_lvl   = lvl_q;
    head_wr_entry = mem_rdata;
    mem_we        = 1'b0;
    mem_waddr     = p_q;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = cur_addr;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          lvl_d  = LvlW'(req_i.level);
          orig_d = LvlW'(req_i.level);
          p_d    = ADDR_BITS'(req_i.block_address);
          if (req_oob) begin
            res_status_d = ST_RANGE;
            res_addr_d   = '0;
            res_lvl_d    = '0;
            state_d      = S_DONE;
          end else if (req_i.mode == MODE_FREE) begin
            state_d = S_F_LOAD;
          end else begin
            state_d = S_A_SCAN;
          end
        end
      end

      // Climb to the first non-empty level.
      S_A_SCAN: begin
        if (head_rd[ADDR_BITS]) begin
          p_d       = head_rd[ADDR_BITS-1:0];
          mem_re    = 1'b1;
          mem_raddr = head_rd[ADDR_BITS-1:0];
          state_d   = S_A_POP;
        end else if (lvl_q == TopLvl) begin
          res_status_d = ST_NOFREE;
          res_addr_d   = '0;
          res_lvl_d    = '0;
          state_d      = S_DONE;
        end else begin
          lvl_d = lvl_q + LvlW'(1);
        end
      end

      // Pop the head: its link becomes the new head.
      S_A_POP: begin
        head_we       = 1'b1;
        head_wr_lvl   = lvl_q;
        head_wr_entry = mem_rdata;
        if (lvl_q == orig_q) begin
          res_status_d = ST_OK;
          res_addr_d   = AddrW'(p_q);
          res_lvl_d    = LevelW'(orig_q);
          state_d      = S_DONE;
        end else begin
          state_d = S_A_SPLIT;
        end
      end

      // Push the upper half as the lone entry one level down.
      S_A_SPLIT: begin
        mem_we        = 1'b1;
        mem_waddr     = bu_buddy;
        mem_wdata     = '0;
        head_we       = 1'b1;
        head_wr_lvl   = lvl_q - LvlW'(1);
        head_wr_entry = {1'b1, bu_buddy};
        lvl_d         = lvl_q - LvlW'(1);
        if ((lvl_q - LvlW'(1)) == orig_q) begin
          res_status_d = ST_OK;
          res_addr_d   = AddrW'(p_q);
          res_lvl_d    = LevelW'(orig_q);
          state_d      = S_DONE;
        end
      end

      S_F_LOAD: begin
        cur_d      = head_rd;
        has_prev_d = 1'b0;
        steps_d    = '0;
        state_d    = S_F_WALK;
      end

      S_F_WALK: begin
        if (cur_q[ADDR_BITS] && !steps_q[ADDR_BITS]) begin
          mem_re    = 1'b1;
          mem_raddr = cur_addr;
          if (lvl_q != TopLvl && bu_match) begin
            state_d = S_F_UNLINK;
          end else begin
            prev_d     = cur_addr;
            has_prev_d = 1'b1;
            steps_d    = steps_q + (ADDR_BITS+1)'(1);
            state_d    = S_F_NEXT;
          end
        end else if (!cur_q[ADDR_BITS]) begin
          // End of list: terminate the block, then link it at the tail.
          mem_we    = 1'b1;
          mem_waddr = p_q;
          mem_wdata = '0;
          state_d   = S_F_APPEND;
        end else begin
          // Walk limit hit on a looped list: drop the block.
          res_status_d = ST_OK;
          res_addr_d   = AddrW'(p_q);
          res_lvl_d    = LevelW'(lvl_q);
          state_d      = S_DONE;
        end
      end

      S_F_NEXT: begin
        cur_d   = mem_rdata;
        state_d = S_F_WALK;
      end

      // Unlink the buddy and retry one level up with the merged block.
      S_F_UNLINK: begin
        if (has_prev_q) begin
          mem_we    = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = mem_rdata;
        end else begin
          head_we       = 1'b1;
          head_wr_lvl   = lvl_q;
          head_wr_entry = mem_rdata;
        end
        p_d     = bu_merged;
        lvl_d   = lvl_q + LvlW'(1);
        state_d = S_F_LOAD;
      end

      S_F_APPEND: begin
        if (has_prev_q) begin
          mem_we    = 1'b1;
          mem_waddr = prev_q;
          mem_wdata = {1'b1, p_q};
        end else begin
          head_we       = 1'b1;
          head_wr_lvl   = lvl_q;
          head_wr_entry = {1'b1, p_q};
        end
        res_status_d = ST_OK;
        res_addr_d   = AddrW'(p_q);
        res_lvl_d    = LevelW'(lvl_q);
        state_d      = S_DONE;
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_lvl_d    = res_lvl_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q        <= lvl_d;
    orig_q       <= orig_d;
    p_q          <= p_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    has_prev_q   <= has_prev_d;
    steps_q      <= steps_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_lvl_q    <= res_lvl_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_lvl_q    <= out_lvl_d;
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.granted_address = out_addr_q;
  assign rsp_o.final_level     = out_lvl_q;

endmodule

// ===== rtl/core/bba_link_mem.sv =====
// Module: per-block next-link memory, one write and one registered read port.
`timescale 1ns / 1ps

module bba_link_mem import bba_pkg::*; #(
  parameter int unsigned ADDR_BITS = AddrBitsDef
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [ADDR_BITS:0]   wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [ADDR_BITS:0]   rdata_o
);

  localparam int unsigned Depth = 1 << ADDR_BITS;

  logic [ADDR_BITS:0] mem_q [Depth];
  logic [ADDR_BITS:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bba_heads.sv =====
// Module: per-level free-list heads with valid bits cleared at reset.
`timescale 1ns / 1ps

module bba_heads import bba_pkg::*; #(
  parameter int unsigned LEVELS    = LevelsDef,
  parameter int unsigned ADDR_BITS = AddrBitsDef,
  localparam int unsigned LvlW     = $clog2(LEVELS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [LvlW-1:0]      rd_lvl_i,
  output logic [ADDR_BITS:0]   rd_entry_o,
  input  logic                 we_i,
  input  logic [LvlW-1:0]      wr_lvl_i,
  input  logic [ADDR_BITS:0]   wr_entry_i
);

  logic [LEVELS-1:0]    valid_q;
  logic [ADDR_BITS-1:0] addr_q [LEVELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[wr_lvl_i] <= wr_entry_i[ADDR_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      addr_q[wr_lvl_i] <= wr_entry_i[ADDR_BITS-1:0];
    end
  end

  assign rd_entry_o = {valid_q[rd_lvl_i], addr_q[rd_lvl_i]};

endmodule

// ===== rtl/core/bba_buddy_unit.sv =====
// Module: shared buddy unit: buddy address, buddy match and merged address.
`timescale 1ns / 1ps

module bba_buddy_unit import bba_pkg::*; #(
  parameter int unsigned LEVELS    = LevelsDef,
  parameter int unsigned ADDR_BITS = AddrBitsDef,
  localparam int unsigned LvlW     = $clog2(LEVELS)
) (
  input  logic [ADDR_BITS-1:0] blk_i,
  input  logic [LvlW-1:0]      lvl_i,
  input  logic [ADDR_BITS-1:0] cmp_i,
  output logic [ADDR_BITS-1:0] buddy_o,
  output logic                 match_o,
  output logic [ADDR_BITS-1:0] merged_o
);

  logic [ADDR_BITS-1:0] size_bit;

  // A level at or above the address width has no size bit inside the mask.
  assign size_bit = {{(ADDR_BITS-1){1'b0}}, 1'b1} << lvl_i;
  assign buddy_o  = blk_i ^ size_bit;
  assign match_o  = (cmp_i == buddy_o);
  assign merged_o = cmp_i & blk_i;

endmodule

// ===== rtl/core/bba_checker.sv =====
// Checker: port-level assertions of the buddy block allocator, bound to the top level.
`timescale 1ns / 1ps

module bba_checker import bba_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [StatusW-1:0] rsp_status_i,
  input logic [AddrW-1:0]   rsp_granted_address_i,
  input logic [LevelW-1:0]  rsp_final_level_i
);

  logic req_xfer;
  logic rsp_xfer;
  logic [1:0] pending_q;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // Count commands accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      pending_q <= pending_q + 2'd1;
    end else if (rsp_xfer && !req_xfer) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_granted_address_i) && $stable(rsp_final_level_i))
    else $error("response changed while stalled");

  a_no_orphan_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_xfer |-> pending_q != 2'd0)
    else $error("response without an outstanding command");

  a_bounded_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |-> pending_q <= 2'd1)
    else $error("more than two commands in flight");

  a_error_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> (rsp_status_i == ST_NOFREE
      || rsp_status_i == ST_RANGE) && rsp_granted_address_i == '0
      && rsp_final_level_i == '0)
    else $error("error response with bad code or nonzero payload");

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .req_valid_i           (req_i.valid),
  .req_ready_i           (req_i.ready),
  .rsp_valid_i           (rsp_o.valid),
  .rsp_ready_i           (rsp_o.ready),
  .rsp_status_i          (rsp_o.status),
  .rsp_granted_address_i (rsp_o.granted_address),
  .rsp_final_level_i     (rsp_o.final_level)
);
